// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker of the value sorter.
// Depends on nothing; every macro samples on a rising edge and skips reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at each rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bvs_pkg.sv =====
// Package of the buffered value sorter: sizes, cell types and controller states.
// Used by the interfaces, the sorting cell and the top level.
package bvs_pkg;

    localparam int DATA_W       = 32;
    localparam int MAX_ELEMENTS = 64;

    // Contents of one cell of the sorting chain.
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
    } cell_data_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic shift_left;
        logic shift_right;
    } cell_ctrl_t;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

// ===== sv/bvs_if.sv =====
// Channel interfaces of the buffered value sorter: input, output and register write.
// Depends on bvs_pkg for the data width.
interface bvs_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [bvs_pkg::DATA_W-1:0] value;
    logic                              final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface bvs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bvs_pkg::DATA_W-1:0] sorted_value;
    logic                              last_out;
    logic                              overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

interface bvs_cfg_if;
    logic valid;
    logic ready;
    logic descending;

    modport source (output valid, output descending, input ready);
    modport sink   (input valid, input descending, output ready);
endinterface

// ===== sv/buffered_value_sorter_top.sv =====
// Buffered value sorter: a chain of cells keeps the stored values in ascending order.
// Fill: one request per cycle; a taken value enters the chain in that cycle, or is dropped and
// flags overflow if the chain is full. Drain: results then leave the output register one per
// cycle unless the output stalls, ascending from cell zero; a descending run first shifts to
// the top cell and leaves from it. No requests are taken while a run drains. Reset empties the
// chain at once (valid bits) and clears the count, the overflow flag and the direction bit.
module buffered_value_sorter_top #(
    parameter int MAX_ELEMENTS = bvs_pkg::MAX_ELEMENTS
) (
    input  logic      clk,
    input  logic      rst_n,
    bvs_in_if.sink    data_in,
    bvs_out_if.source data_out,
    bvs_cfg_if.sink   cfg
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    bvs_pkg::state_t                   state_reg;
    bvs_pkg::state_t                   state_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              dropped_reg;
    logic                              dropped_next;
    logic                              run_ovf_reg;
    logic                              run_ovf_next;
    logic                              descending_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [bvs_pkg::DATA_W-1:0] out_value_reg;
    logic                              out_last_reg;
    logic                              out_ovf_reg;

    bvs_pkg::cell_ctrl_t ctrl;
    bvs_pkg::cell_data_t cell_q [MAX_ELEMENTS];
    logic                cell_ge [MAX_ELEMENTS];
    bvs_pkg::cell_data_t head;
    logic                accept;
    logic                full;
    logic                can_load;
    logic                emit;

    // Register write port.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            descending_reg <= cfg.descending;
        end
    end

    // Chain of sorting cells.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++)
        begin : g_cell
            bvs_pkg::cell_data_t left_d;
            bvs_pkg::cell_data_t right_d;
            logic                ge_l;

            if (gi == 0)
            begin : g_first
                assign left_d = '0;
                assign ge_l   = 1'b0;
            end
            else
            begin : g_mid
                assign left_d = cell_q[gi-1];
                assign ge_l   = cell_ge[gi-1];
            end

            if (gi == MAX_ELEMENTS - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_inner
                assign right_d = cell_q[gi+1];
            end

            bvs_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_value  (data_in.value),
                .ge_left    (ge_l),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_q[gi]),
                .ge         (cell_ge[gi])
            );
        end
    endgenerate

    // Handshake decode.
    assign data_in.ready = (state_reg == bvs_pkg::ST_FILL);
    assign accept        = data_in.valid && data_in.ready;
    assign full          = (count_reg == CNT_W'(MAX_ELEMENTS));
    assign can_load      = !out_valid_reg || data_out.ready;
    assign head          = descending_reg ? cell_q[MAX_ELEMENTS-1] : cell_q[0];
    assign emit          = (state_reg == bvs_pkg::ST_DRAIN) && head.valid && can_load;

    // Controller: fill the chain, then drain it through the output register.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        run_ovf_next = run_ovf_reg;
        ctrl         = '0;
        unique case (state_reg)
            bvs_pkg::ST_FILL:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    if (data_in.final_item)
                    begin
                        run_ovf_next = dropped_reg || full;
                        dropped_next = 1'b0;
                        state_next   = bvs_pkg::ST_DRAIN;
                    end
                end
            end
            bvs_pkg::ST_DRAIN:
            begin
                if (emit)
                begin
                    ctrl.shift_left  = !descending_reg;
                    ctrl.shift_right = descending_reg;
                    count_next       = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = bvs_pkg::ST_FILL;
                    end
                end
                else if (descending_reg && !head.valid)
                begin
                    // Move the run toward the top cell before output starts.
                    ctrl.shift_right = 1'b1;
                end
            end
            default:
            begin
                state_next = bvs_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bvs_pkg::ST_FILL;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            run_ovf_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            run_ovf_reg <= run_ovf_next;
        end
    end

    // Output register.
    assign out_valid_next = emit || (out_valid_reg && !data_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= head.value;
            out_last_reg  <= (count_reg == CNT_W'(1));
            out_ovf_reg   <= run_ovf_reg;
        end
    end

    assign data_out.valid        = out_valid_reg;
    assign data_out.sorted_value = out_value_reg;
    assign data_out.last_out     = out_last_reg;
    assign data_out.overflow     = out_ovf_reg;

endmodule

// ===== sv/bvs_cell.sv =====
// One cell of the insertion-sorting chain: holds one value and its valid bit.
// Depends on bvs_pkg for the cell types and the data width.
module bvs_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bvs_pkg::cell_ctrl_t               ctrl,
    input  logic signed [bvs_pkg::DATA_W-1:0] new_value,
    input  logic                              ge_left,
    input  bvs_pkg::cell_data_t               left_data,
    input  bvs_pkg::cell_data_t               right_data,
    output bvs_pkg::cell_data_t               data,
    output logic                              ge
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [bvs_pkg::DATA_W-1:0] value_reg;
    logic signed [bvs_pkg::DATA_W-1:0] value_next;

    // The new value belongs at or before this cell when the cell is empty or holds a
    // larger value; the chain stays ascending, so this flag is monotone along it.
    assign ge = !valid_reg || (new_value < value_reg);

    // Insert, shift toward cell zero, or shift away from it.
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (ge && !ge_left)
            begin
                valid_next = 1'b1;
                value_next = new_value;
            end
            else if (ge)
            begin
                valid_next = left_data.valid;
                value_next = left_data.value;
            end
        end
        else if (ctrl.shift_left)
        begin
            valid_next = right_data.valid;
            value_next = right_data.value;
        end
        else if (ctrl.shift_right)
        begin
            valid_next = left_data.valid;
            value_next = left_data.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign data.valid = valid_reg;
    assign data.value = value_reg;

endmodule

// ===== sv/bvs_checker.sv =====
// Port-level checker for the buffered value sorter, bound to its top level.
// Depends on assert_macros.svh and the channel interfaces of the top level.
`include "assert_macros.svh"

module bvs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_final,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic out_ovf,
    input logic signed [bvs_pkg::DATA_W-1:0] out_value
);

    // A final request starts a run, so no request is taken in the next cycle.
    `ASSERT_NEXT(a_final_blocks_input, clk, rst_n, in_valid && in_ready && in_final, !in_ready, "input taken right after a final request")

    // The input side only closes because of a final request.
    `ASSERT_IMPLIES(a_ready_falls_on_final, clk, rst_n, $fell(in_ready), $past(in_valid && in_ready && in_final), "input closed without a final request")

    // The overflow mark is the same on every result of one run.
    `ASSERT_NEXT(a_ovf_per_run, clk, rst_n, out_valid && out_ready && !out_last, !out_valid || (out_ovf == $past(out_ovf)), "overflow changed inside a run")

    // A stalled result holds its contents.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_last), "stalled result changed")

endmodule

bind buffered_value_sorter_top bvs_checker u_bvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (data_in.valid),
    .in_ready  (data_in.ready),
    .in_final  (data_in.final_item),
    .out_valid (data_out.valid),
    .out_ready (data_out.ready),
    .out_last  (data_out.last_out),
    .out_ovf   (data_out.overflow),
    .out_value (data_out.sorted_value)
);

// ===== verif/bvs_sort_checker.sv =====
// Checker of the buffered value sorter: watches the input, output and register channels,
// predicts each sorted run and compares it with what the block sends out.
// Depends on bvs_pkg and the channel interfaces in bvs_if.
module bvs_sort_checker (
    input  logic clk,
    input  logic rst_n,
    bvs_in_if    in_ch,
    bvs_out_if   out_ch,
    bvs_cfg_if   cfg_ch,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One expected result of a sorted run.
    typedef struct {
        logic signed [bvs_pkg::DATA_W-1:0] value;
        logic                              last;
        logic                              ovf;
    } sorted_res_t;

    // Predicted state of the block.
    logic signed [bvs_pkg::DATA_W-1:0] held_values [bvs_pkg::MAX_ELEMENTS];
    int                                held_count;
    logic                              dropped;
    logic                              order_desc;
    sorted_res_t                       run_q [$];

    initial errors = 0;

    // Prints one mismatch line and counts it.
    task report(input string what, input logic signed [bvs_pkg::DATA_W-1:0] want,
                input logic signed [bvs_pkg::DATA_W-1:0] got);
        $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict
        logic signed [bvs_pkg::DATA_W-1:0] key;
        sorted_res_t                       want;
        int                                p;
        int                                k;

        if (!rst_n)
        begin
            held_count = 0;
            dropped    = 1'b0;
            order_desc = 1'b0;
            run_q.delete();
            pending   <= 0;
        end
        else
        begin
            // Compare an accepted result with the oldest expectation.
            if (out_ch.valid && out_ch.ready)
            begin
                if (run_q.size() == 0)
                begin
                    report("unexpected result", 0, out_ch.sorted_value);
                end
                else
                begin
                    want = run_q.pop_front();
                    if (out_ch.sorted_value !== want.value)
                        report("sorted_value", want.value, out_ch.sorted_value);
                    if (out_ch.last_out !== want.last)
                        report("last_out", want.last, out_ch.last_out);
                    if (out_ch.overflow !== want.ovf)
                        report("overflow", want.ovf, out_ch.overflow);
                end
            end

            // Direction register write.
            if (cfg_ch.valid && cfg_ch.ready)
                order_desc = cfg_ch.descending;

            // Store the value of a request, or note that it was dropped.
            if (in_ch.valid && in_ch.ready)
            begin
                if (held_count < bvs_pkg::MAX_ELEMENTS)
                begin
                    held_values[held_count] = in_ch.value;
                    held_count++;
                end
                else
                begin
                    dropped = 1'b1;
                end

                // A final request sorts the stored values and queues the whole run.
                if (in_ch.final_item)
                begin
                    for (k = 1; k < held_count; k++)
                    begin
                        key = held_values[k];
                        p   = k;
                        while (p > 0 && (order_desc ? (key > held_values[p-1])
                                                    : (key < held_values[p-1])))
                        begin
                            held_values[p] = held_values[p-1];
                            p--;
                        end
                        held_values[p] = key;
                    end
                    for (k = 0; k < held_count; k++)
                    begin
                        want.value = held_values[k];
                        want.last  = (k == held_count - 1);
                        want.ovf   = dropped;
                        run_q.push_back(want);
                    end
                    held_count = 0;
                    dropped    = 1'b0;
                end
            end
            pending <= run_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top of the buffered value sorter: clock, reset, requests, register writes
// and output stalls. Depends on bvs_pkg, bvs_if, the block and bvs_sort_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 80;
    localparam int REQ_TARGET   = 350;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycle_count;
    int   sent;
    int   gap_max;
    int   stall_max;

    bvs_in_if  in_ch ();
    bvs_out_if out_ch ();
    bvs_cfg_if cfg_ch ();

    buffered_value_sorter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .data_in  (in_ch),
        .data_out (out_ch),
        .cfg      (cfg_ch)
    );

    bvs_sort_checker sort_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Output side: stalls a random number of cycles before each result.
    initial
    begin : receiver
        int stall;

        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, stall_max);
            if (stall != 0)
            begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Sends one request after a random gap and waits until it is taken.
    task send_req(input logic signed [bvs_pkg::DATA_W-1:0] v, input logic fin);
        int gap;

        gap = $urandom_range(0, gap_max);
        @(negedge clk);
        if (gap != 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.value      = v;
        in_ch.final_item = fin;
        do @(posedge clk); while (!in_ch.ready);
        sent++;
    endtask

    // Sends a set of random values, the last one marked final.
    task send_set(input int count);
        logic signed [bvs_pkg::DATA_W-1:0] v;
        int                                k;

        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 7)) inside
                0:       v = 32'sh7FFF_FFFF;
                1:       v = 32'sh8000_0000;
                2, 3:    v = $signed($urandom_range(0, 8)) - 4;
                default: v = $urandom;
            endcase
            send_req(v, k == count - 1);
        end
    endtask

    // Holds off requests until every expected result has come and the block is idle.
    task settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    // Writes the direction register.
    task write_direction(input logic desc);
        @(negedge clk);
        cfg_ch.valid      = 1'b1;
        cfg_ch.descending = desc;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        int phase;
        int k;
        int set_len;

        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.value       = '0;
        in_ch.final_item  = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.descending = 1'b0;
        sent              = 0;
        gap_max           = 6;
        stall_max         = 6;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: single final request, extremes, equal values, both directions.
        settle();
        write_direction(1'b0);
        send_req(32'sh8000_0000, 1'b1);
        send_req(32'sh7FFF_FFFF, 1'b0);
        send_req(-1, 1'b0);
        send_req(0, 1'b0);
        send_req(1, 1'b0);
        send_req(32'sh8000_0000, 1'b1);
        send_req(5, 1'b0);
        send_req(5, 1'b0);
        send_req(-5, 1'b1);
        settle();
        write_direction(1'b1);
        send_req(32'sh7FFF_FFFF, 1'b0);
        send_req(32'sh8000_0000, 1'b0);
        send_req(0, 1'b0);
        send_req(-1, 1'b0);
        send_req(1, 1'b1);
        send_req(-7, 1'b0);
        send_req(-7, 1'b1);

        // Random sets: mostly small, a few that fill the store or overflow it.
        phase = 0;
        while (sent < REQ_TARGET)
        begin
            settle();
            write_direction(1'(phase % 2));
            gap_max   = (phase % 3 == 0) ? 0 : 6;
            stall_max = (phase % 3 == 1) ? 0 : 6;
            for (k = 0; k < 6; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    set_len = $urandom_range(60, 70);
                else
                    set_len = $urandom_range(1, 8);
                if (k == 0 && phase == 0)
                    set_len = bvs_pkg::MAX_ELEMENTS;
                else if (k == 0 && phase == 1)
                    set_len = bvs_pkg::MAX_ELEMENTS + 1;
                else if (k == 0 && phase == 2)
                    set_len = bvs_pkg::MAX_ELEMENTS + 6;
                send_set(set_len);
            end
            phase++;
        end

        settle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
